// File: hw/rtl/sal_pkg.sv
// Shared types for the suffix array / LCP builder.
// Used by sal_ctrl, sal_dp and suffix_array_lcp_builder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

	localparam int SYM_W = 8;
	localparam int POS_W = 6;

	// Datapath commands issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_INIT_WR,
		CMD_RD_KEY,
		CMD_SET_KEY,
		CMD_RD_PREV,
		CMD_SET_PAIR,
		CMD_TXT_RD,
		CMD_CMP_STEP,
		CMD_SHIFT,
		CMD_PLACE,
		CMD_EMIT_START,
		CMD_RD_RANK,
		CMD_SET_CUR,
		CMD_FIRST,
		CMD_LCP_DONE,
		CMD_ADVANCE
	} cmd_t;

	// Datapath status seen by the controller.
	typedef struct packed {
		logic eot;
		logic init_last;
		logic i_end;
		logic j_zero;
		logic cmp_more;
		logic cmp_less;
		logic r_first;
		logic r_last;
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/sal_dp.sv
// Datapath: text and order memories, sort/compare counters, output register.
// Depends on sal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sal_dp #(
	parameter int MAX_TEXT = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sal_pkg::cmd_t              cmd,
	output sal_pkg::status_t                status,
	input  wire logic [sal_pkg::SYM_W-1:0]  symbol,
	input  wire logic                       end_of_text,
	output logic [sal_pkg::POS_W-1:0]       suffix_start,
	output logic [sal_pkg::POS_W-1:0]       common_prefix,
	output logic                            truncated,
	output logic                            last_result
);
	import sal_pkg::*;

	localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int CW = $clog2(MAX_TEXT + 1);
	localparam int SW = CW + 1;

	logic [SYM_W-1:0] text_mem [MAX_TEXT];
	logic [AW-1:0]    order_mem [MAX_TEXT];

	logic [CW-1:0]    len_q, i_q, j_q, k_q, r_q;
	logic             ovf_q;
	logic [AW-1:0]    key_q, p_q, q_q, cur_q, prev_q;
	logic [SYM_W-1:0] ta_q, tb_q;
	logic [AW-1:0]    ord_rd_q;

	logic [POS_W-1:0] sstart_q, lcp_q;
	logic             trunc_q, last_q;

	logic [SW-1:0]    pa, qa;
	logic             pend, qend;
	logic [CW-1:0]    jm1;
	logic [AW-1:0]    ord_raddr;

	assign pa   = SW'(p_q) + SW'(k_q);
	assign qa   = SW'(q_q) + SW'(k_q);
	assign pend = pa >= SW'(len_q);
	assign qend = qa >= SW'(len_q);
	assign jm1  = j_q - CW'(1);

	assign status.eot       = end_of_text;
	assign status.init_last = (i_q + CW'(1)) == len_q;
	assign status.i_end     = i_q >= len_q;
	assign status.j_zero    = j_q == '0;
	assign status.cmp_more  = !pend && !qend && (ta_q == tb_q);
	assign status.cmp_less  = pend ? !qend : (!qend && (ta_q < tb_q));
	assign status.r_first   = r_q == '0;
	assign status.r_last    = (r_q + CW'(1)) == len_q;

	always_comb begin
		case (cmd)
			CMD_RD_KEY:  ord_raddr = i_q[AW-1:0];
			CMD_RD_PREV: ord_raddr = jm1[AW-1:0];
			default:     ord_raddr = r_q[AW-1:0];
		endcase
	end

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD && len_q < CW'(MAX_TEXT)) begin
			text_mem[len_q[AW-1:0]] <= symbol;
		end
		ta_q <= text_mem[pa[AW-1:0]];
		tb_q <= text_mem[qa[AW-1:0]];
		case (cmd)
			CMD_INIT_WR: order_mem[i_q[AW-1:0]] <= i_q[AW-1:0];
			CMD_SHIFT:   order_mem[j_q[AW-1:0]] <= q_q;
			CMD_PLACE:   order_mem[j_q[AW-1:0]] <= key_q;
			default:     ;
		endcase
		ord_rd_q <= order_mem[ord_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			r_q   <= '0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					i_q <= '0;
					if (len_q < CW'(MAX_TEXT)) len_q <= len_q + CW'(1);
					else ovf_q <= 1'b1;
				end
				CMD_INIT_WR:    i_q <= status.init_last ? CW'(1) : i_q + CW'(1);
				CMD_SET_KEY:    j_q <= i_q;
				CMD_SET_PAIR:   k_q <= '0;
				CMD_CMP_STEP:   k_q <= k_q + CW'(1);
				CMD_SHIFT:      j_q <= jm1;
				CMD_PLACE:      i_q <= i_q + CW'(1);
				CMD_EMIT_START: r_q <= '0;
				CMD_SET_CUR:    k_q <= '0;
				CMD_ADVANCE: begin
					r_q <= r_q + CW'(1);
					if (status.r_last) begin
						len_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_SET_KEY: key_q <= ord_rd_q;
			CMD_SET_PAIR: begin
				q_q <= ord_rd_q;
				p_q <= key_q;
			end
			CMD_SET_CUR: begin
				cur_q <= ord_rd_q;
				p_q   <= prev_q;
				q_q   <= ord_rd_q;
			end
			CMD_FIRST, CMD_LCP_DONE: begin
				sstart_q <= POS_W'(cur_q);
				lcp_q    <= (cmd == CMD_FIRST) ? '0 : POS_W'(k_q);
				trunc_q  <= ovf_q;
				last_q   <= status.r_last;
			end
			CMD_ADVANCE: prev_q <= cur_q;
			default: ;
		endcase
	end

	assign suffix_start  = sstart_q;
	assign common_prefix = lcp_q;
	assign truncated     = trunc_q;
	assign last_result   = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/sal_ctrl.sv
// Controller: load, insertion sort, LCP and emit sequencing.
// Depends on sal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sal_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire sal_pkg::status_t status,
	output sal_pkg::cmd_t         cmd
);
	import sal_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_INIT, ST_OUTER, ST_OKEY, ST_JCHK, ST_JLOAD, ST_CRD_S, ST_CEV_S,
		ST_SHIFT, ST_PLACE, ST_ERD, ST_EGET, ST_EFIRST, ST_CRD_L, ST_CEV_L, ST_EOUT
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = state_q != ST_LOAD;
	assign out_valid = state_q == ST_EOUT;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NOP;
		case (state_q)
			ST_LOAD: if (in_valid) begin
				cmd = CMD_LOAD;
				if (status.eot) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd = CMD_INIT_WR;
				if (status.init_last) state_d = ST_OUTER;
			end
			ST_OUTER: begin
				if (status.i_end) begin
					cmd     = CMD_EMIT_START;
					state_d = ST_ERD;
				end else begin
					cmd     = CMD_RD_KEY;
					state_d = ST_OKEY;
				end
			end
			ST_OKEY: begin
				cmd     = CMD_SET_KEY;
				state_d = ST_JCHK;
			end
			ST_JCHK: begin
				if (status.j_zero) state_d = ST_PLACE;
				else begin
					cmd     = CMD_RD_PREV;
					state_d = ST_JLOAD;
				end
			end
			ST_JLOAD: begin
				cmd     = CMD_SET_PAIR;
				state_d = ST_CRD_S;
			end
			ST_CRD_S: begin
				cmd     = CMD_TXT_RD;
				state_d = ST_CEV_S;
			end
			ST_CEV_S: begin
				if (status.cmp_more) begin
					cmd     = CMD_CMP_STEP;
					state_d = ST_CRD_S;
				end else if (status.cmp_less) state_d = ST_SHIFT;
				else state_d = ST_PLACE;
			end
			ST_SHIFT: begin
				cmd     = CMD_SHIFT;
				state_d = ST_JCHK;
			end
			ST_PLACE: begin
				cmd     = CMD_PLACE;
				state_d = ST_OUTER;
			end
			ST_ERD: begin
				cmd     = CMD_RD_RANK;
				state_d = ST_EGET;
			end
			ST_EGET: begin
				cmd     = CMD_SET_CUR;
				state_d = status.r_first ? ST_EFIRST : ST_CRD_L;
			end
			ST_EFIRST: begin
				cmd     = CMD_FIRST;
				state_d = ST_EOUT;
			end
			ST_CRD_L: begin
				cmd     = CMD_TXT_RD;
				state_d = ST_CEV_L;
			end
			ST_CEV_L: begin
				if (status.cmp_more) begin
					cmd     = CMD_CMP_STEP;
					state_d = ST_CRD_L;
				end else begin
					cmd     = CMD_LCP_DONE;
					state_d = ST_EOUT;
				end
			end
			ST_EOUT: if (!out_stall) begin
				cmd     = CMD_ADVANCE;
				state_d = status.r_last ? ST_LOAD : ST_ERD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

// File: hw/rtl/suffix_array_lcp_builder.sv
// Top level of the suffix array / LCP builder: controller plus datapath.
// Depends on sal_pkg, sal_ctrl, sal_dp.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid / in_stall       | symbol[7:0], end_of_text
// output   | out_valid / out_stall     | suffix_start, common_prefix, truncated,
//          |                           | last_result
//
// Loading accepts one byte per cycle. After the end byte the order table is
// filled with the positions in order, then the block sorts by insertion,
// comparing suffixes one text byte at a time (registered memory reads). Each
// rank after the first then compares its suffix with the previous rank's byte
// by byte to find their common prefix (the first rank gets zero), and the
// result stays on offer until it is taken.
// Reset is asynchronous and active low; memories are not cleared.
// The input is stalled from the end byte until the last result is taken;
// a stalled result holds in the output register.

module suffix_array_lcp_builder #(
	parameter int MAX_TEXT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  symbol,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       suffix_start,
	output logic [5:0]       common_prefix,
	output logic             truncated,
	output logic             last_result
);
	import sal_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence load, sort and emit phases.
	sal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold text, order table and the result register.
	sal_dp #(.MAX_TEXT(MAX_TEXT)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.symbol        (symbol),
		.end_of_text   (end_of_text),
		.suffix_start  (suffix_start),
		.common_prefix (common_prefix),
		.truncated     (truncated),
		.last_result   (last_result)
	);

`ifndef ASSERT_OFF
	// Never take input while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("input open while result pending");

	// A plain byte keeps the block loading.
	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !end_of_text |=> !in_stall)
		else $error("left load phase without end byte");

	// The last transaction returns the block to loading.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_result |=> !in_stall && !out_valid)
		else $error("run did not end after last result");
`endif

endmodule

`default_nettype wire

// File: verif/suffix_array_lcp_builder_test.sv
// Self-checking testbench for suffix_array_lcp_builder: streams texts through the
// input channel and compares every sorted rank against an in-bench suffix sorter.
// Depends on sal_pkg and the suffix_array_lcp_builder RTL.
`timescale 1ns / 1ps

module suffix_array_lcp_builder_test;

	localparam int CAP = 64;

	typedef struct packed {
		logic [7:0] sym;
		logic       eot;
	} byte_item_t;

	typedef struct packed {
		logic [5:0] start;
		logic [5:0] lcp;
		logic       trunc;
		logic       last;
	} rank_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] symbol;
	logic       end_of_text;
	logic       out_valid;
	logic       out_stall;
	logic [5:0] suffix_start;
	logic [5:0] common_prefix;
	logic       truncated;
	logic       last_result;

	suffix_array_lcp_builder #(.MAX_TEXT(CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.symbol(symbol), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.suffix_start(suffix_start), .common_prefix(common_prefix),
		.truncated(truncated), .last_result(last_result)
	);

	// Generate the clock: 6 ns high, 6 ns low.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	byte_item_t pending_bytes[$];
	rank_t      expected_ranks[$];
	int         mismatches = 0;
	bit         quiet_mode = 0;  // no idling on either side while set
	bit         hold_off = 0;    // receiver refuses results while set

	// Predictor state: a copy of the text store and its fill.
	logic [7:0] text_copy[CAP];
	int         fill = 0;
	bit         overflowed = 0;
	int         order_tab[CAP];

	function automatic int match_len(int p, int q, int n);
		int k;
		k = 0;
		while (p + k < n && q + k < n && text_copy[p + k] == text_copy[q + k])
			k++;
		return k;
	endfunction

	function automatic bit sorts_first(int p, int q, int n);
		int k;
		k = match_len(p, q, n);
		if (p + k >= n)
			return q + k < n;
		if (q + k >= n)
			return 0;
		return text_copy[p + k] < text_copy[q + k];
	endfunction

	// Advance the predictor by one accepted byte; on the end byte, sort the
	// suffixes by insertion and queue one expected rank per stored position.
	task automatic predict_byte(byte_item_t it);
		int j, key;
		rank_t r;
		if (fill < CAP) begin
			text_copy[fill] = it.sym;
			fill++;
		end else
			overflowed = 1;
		if (!it.eot)
			return;
		for (int i = 0; i < fill; i++)
			order_tab[i] = i;
		for (int i = 1; i < fill; i++) begin
			key = order_tab[i];
			j = i;
			while (j > 0 && sorts_first(key, order_tab[j - 1], fill)) begin
				order_tab[j] = order_tab[j - 1];
				j--;
			end
			order_tab[j] = key;
		end
		for (int i = 0; i < fill; i++) begin
			r.start = 6'(order_tab[i]);
			r.lcp   = (i == 0) ? 6'd0 : 6'(match_len(order_tab[i - 1], order_tab[i], fill));
			r.trunc = overflowed;
			r.last  = (i == fill - 1);
			expected_ranks.push_back(r);
		end
		fill = 0;
		overflowed = 0;
	endtask

	function automatic bit idle_now();
		return !quiet_mode && ($urandom_range(99) < 11);
	endfunction

	// Driver: present the head of the queue; hold the payload while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			symbol      <= '0;
			end_of_text <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte('{sym: symbol, eot: end_of_text});
				void'(pending_bytes.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (pending_bytes.size() != 0 && !idle_now()) begin
					in_valid    <= 1'b1;
					symbol      <= pending_bytes[0].sym;
					end_of_text <= pending_bytes[0].eot;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted transaction against the oldest expected rank,
	// and choose the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		rank_t want, got;
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				got = '{start: suffix_start, lcp: common_prefix, trunc: truncated,
				        last: last_result};
				if (expected_ranks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_ranks.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: start exp %0d got %0d, lcp exp %0d got %0d,",
							          " trunc exp %0b got %0b, last exp %0b got %0b"},
							         want.start, got.start, want.lcp, got.lcp,
							         want.trunc, got.trunc, want.last, got.last);
					end
				end
			end
			if (hold_off)
				out_stall <= 1'b1;
			else
				out_stall <= idle_now();
		end
	end

	task automatic add_text(int len, bit narrow);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			it.sym = narrow ? 8'($urandom_range(1) ? 8'h61 : 8'h62) : 8'($urandom);
			it.eot = (i == len - 1);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic add_fixed(byte_item_t it);
		pending_bytes.push_back(it);
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || expected_ranks.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single byte, extremes, runs of one symbol, repeats, overflow.
		add_fixed('{sym: 8'h00, eot: 1'b1});
		add_fixed('{sym: 8'hff, eot: 1'b0});
		add_fixed('{sym: 8'h00, eot: 1'b1});
		for (int i = 0; i < 5; i++) add_fixed('{sym: 8'haa, eot: i == 4});
		add_fixed('{sym: 8'h55, eot: 1'b0});
		add_fixed('{sym: 8'haa, eot: 1'b0});
		add_fixed('{sym: 8'h55, eot: 1'b0});
		add_fixed('{sym: 8'haa, eot: 1'b1});
		drain();
		// Full store, then two dropped bytes and a dropped end byte that still closes the text.
		quiet_mode = 1;
		for (int i = 0; i < CAP + 3; i++)
			add_fixed('{sym: 8'(i % 3 == 0 ? 8'h41 : 8'h42), eot: i == CAP + 2});
		drain();
		// Exactly full, no drop.
		add_text(CAP, 1);
		drain();
		quiet_mode = 0;

		// Pressure: receiver holds off results while texts keep coming.
		add_text(10, 0);
		add_text(6, 1);
		fork
			begin
				hold_off <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		drain();

		// Random: mostly short texts, about half over a two-symbol alphabet to get long common prefixes.
		sent = 0;
		while (sent < 150) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(CAP + 4, 40) : $urandom_range(12, 1);
			quiet_mode = ($urandom_range(9) == 0);
			add_text(len, 1'($urandom_range(1)));
			sent += len;
			if ($urandom_range(3) == 0) drain();
		end
		quiet_mode = 0;
		drain();
		if (mismatches == 0)
			$display("** suffix_array_lcp_builder: PASSED **");
		else
			$display("** suffix_array_lcp_builder: FAILED **");
		$finish;
	end

	// Bound the run well past the slowest correct run.
	initial begin
		#200ms;
		$display("** suffix_array_lcp_builder: FAILED **");
		$finish;
	end

endmodule
